/* rtl/core/rmh_pkg.sv */
// Shared types and constants for the running median block.
// Used by rmh_cell, rmh_chain and running_median_two_heap; depends on nothing.
package rmh_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int MED_W        = 33;
  localparam int COUNT_OUT_W  = 11;
  localparam int CAPACITY_DEF = 1024;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t                    op;
    logic signed [SAMPLE_W-1:0]  key;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_MOVE,
    S_DONE
  } state_t;

endpackage

/* rtl/core/running_median_two_heap.sv */
// Top level of the running median block: sequencer, counts and result register.
// Depends on rmh_pkg and rmh_chain.
//
// Each accepted sample transaction yields one result: twice the median of all
// samples held, the held count, and a drop flag once CAPACITY samples are held.
// The lower and upper halves sit in two sorted chains of cells, each of which
// inserts or removes a value by shifting its cells. A stored sample passes
// through insert (S_PUSH), rebalance (S_MOVE) and result (S_DONE) states, and
// the next sample is accepted back in S_IDLE. A dropped sample goes straight
// from S_IDLE to S_DONE, skipping insert and rebalance.
// A new sample is accepted while an earlier result still waits to be taken;
// the result stage waits only if that result is still held.
module running_median_two_heap #(
  parameter int CAPACITY = rmh_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rmh_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rmh_pkg::MED_W-1:0]    out_median_doubled,
  output logic [rmh_pkg::COUNT_OUT_W-1:0]     out_held_count,
  output logic                                out_dropped
);

  localparam int DEPTH = CAPACITY / 2 + 2;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int HW    = $clog2(CAPACITY + 1);
  localparam int OW    = rmh_pkg::COUNT_OUT_W;

  rmh_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] lo_cnt_r, lo_cnt_nxt;
  logic [CW-1:0] up_cnt_r, up_cnt_nxt;
  logic signed [rmh_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic go_low_r, go_low_nxt;
  logic dropped_r, dropped_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [rmh_pkg::MED_W-1:0] out_median_r, out_median_nxt;
  logic [OW-1:0] out_held_r, out_held_nxt;
  logic out_dropped_r, out_dropped_nxt;

  rmh_pkg::cell_cmd_t lo_cmd, up_cmd;
  logic signed [rmh_pkg::SAMPLE_W-1:0] lo_top, up_top;
  logic [HW-1:0] held_w;
  logic [HW+OW-1:0] held_ext;
  logic signed [rmh_pkg::MED_W-1:0] median_w;
  logic in_accept, out_take;

  rmh_chain #(.DEPTH(DEPTH), .CW(CW), .IS_MAX(1'b1)) u_lower (
    .clk (clk), .cmd (lo_cmd), .cnt (lo_cnt_r), .top (lo_top)
  );

  rmh_chain #(.DEPTH(DEPTH), .CW(CW), .IS_MAX(1'b0)) u_upper (
    .clk (clk), .cmd (up_cmd), .cnt (up_cnt_r), .top (up_top)
  );

  assign held_w    = HW'(lo_cnt_r) + HW'(up_cnt_r);
  assign held_ext  = (HW + OW)'(held_w);
  assign in_stall  = (state_r != rmh_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  always_comb begin
    if (lo_cnt_r == '0) begin
      median_w = '0;
    end else if ((lo_cnt_r > up_cnt_r) || (up_cnt_r == '0)) begin
      median_w = {lo_top, 1'b0};
    end else begin
      median_w = rmh_pkg::MED_W'(lo_top) + rmh_pkg::MED_W'(up_top);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    lo_cnt_nxt      = lo_cnt_r;
    up_cnt_nxt      = up_cnt_r;
    sample_nxt      = sample_r;
    go_low_nxt      = go_low_r;
    dropped_nxt     = dropped_r;
    out_valid_nxt   = out_take ? 1'b0 : out_valid_r;
    out_median_nxt  = out_median_r;
    out_held_nxt    = out_held_r;
    out_dropped_nxt = out_dropped_r;
    lo_cmd.op       = rmh_pkg::OP_HOLD;
    lo_cmd.key      = sample_r;
    up_cmd.op       = rmh_pkg::OP_HOLD;
    up_cmd.key      = sample_r;

    unique case (state_r)
      rmh_pkg::S_IDLE: begin
        if (in_accept) begin
          sample_nxt = in_sample;
          go_low_nxt = (lo_cnt_r == '0) || (in_sample <= lo_top);
          if (held_w >= HW'(CAPACITY)) begin
            dropped_nxt = 1'b1;
            state_nxt   = rmh_pkg::S_DONE;
          end else begin
            dropped_nxt = 1'b0;
            state_nxt   = rmh_pkg::S_PUSH;
          end
        end
      end
      rmh_pkg::S_PUSH: begin
        if (go_low_r) begin
          lo_cmd.op  = rmh_pkg::OP_INSERT;
          lo_cnt_nxt = lo_cnt_r + 1'b1;
        end else begin
          up_cmd.op  = rmh_pkg::OP_INSERT;
          up_cnt_nxt = up_cnt_r + 1'b1;
        end
        state_nxt = rmh_pkg::S_MOVE;
      end
      rmh_pkg::S_MOVE: begin
        if (lo_cnt_r > up_cnt_r + 1'b1) begin
          lo_cmd.op  = rmh_pkg::OP_POP;
          up_cmd.op  = rmh_pkg::OP_INSERT;
          up_cmd.key = lo_top;
          lo_cnt_nxt = lo_cnt_r - 1'b1;
          up_cnt_nxt = up_cnt_r + 1'b1;
        end else if (up_cnt_r > lo_cnt_r) begin
          up_cmd.op  = rmh_pkg::OP_POP;
          lo_cmd.op  = rmh_pkg::OP_INSERT;
          lo_cmd.key = up_top;
          up_cnt_nxt = up_cnt_r - 1'b1;
          lo_cnt_nxt = lo_cnt_r + 1'b1;
        end
        state_nxt = rmh_pkg::S_DONE;
      end
      rmh_pkg::S_DONE: begin
        if (!out_valid_r || out_take) begin
          out_valid_nxt   = 1'b1;
          out_median_nxt  = median_w;
          out_held_nxt    = held_ext[OW-1:0];
          out_dropped_nxt = dropped_r;
          state_nxt       = rmh_pkg::S_IDLE;
        end
      end
      default: state_nxt = rmh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmh_pkg::S_IDLE;
      lo_cnt_r    <= '0;
      up_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lo_cnt_r    <= lo_cnt_nxt;
      up_cnt_r    <= up_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r      <= sample_nxt;
    go_low_r      <= go_low_nxt;
    dropped_r     <= dropped_nxt;
    out_median_r  <= out_median_nxt;
    out_held_r    <= out_held_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = out_median_r;
  assign out_held_count     = out_held_r;
  assign out_dropped        = out_dropped_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_w <= HW'(CAPACITY))
    else $error("held count exceeds capacity");

  a_balanced_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmh_pkg::S_IDLE) |-> (lo_cnt_r == up_cnt_r) || (lo_cnt_r == up_cnt_r + 1'b1))
    else $error("halves out of balance between transactions");

  a_halves_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmh_pkg::S_IDLE && lo_cnt_r != '0 && up_cnt_r != '0) |-> (lo_top <= up_top))
    else $error("lower top above upper top");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmh_pkg::S_DONE && dropped_r) |-> (held_w == HW'(CAPACITY)))
    else $error("sample dropped while store not full");

  a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && held_w < HW'(CAPACITY)) |=> (state_r == rmh_pkg::S_PUSH))
    else $error("accepted sample not inserted");

endmodule

/* rtl/core/rmh_cell.sv */
// One cell of a sorted priority chain: holds one value and shifts with its neighbors.
// Depends on rmh_pkg for the command type and sample width.
module rmh_cell #(
  parameter int INDEX  = 0,
  parameter int CW     = 10,
  parameter bit IS_MAX = 1'b1
) (
  input  logic                                clk,
  input  rmh_pkg::cell_cmd_t                  cmd,
  input  logic [CW-1:0]                       cnt,
  input  logic signed [rmh_pkg::SAMPLE_W-1:0] prev_val,
  input  logic                                prev_keep,
  input  logic signed [rmh_pkg::SAMPLE_W-1:0] next_val,
  output logic signed [rmh_pkg::SAMPLE_W-1:0] val,
  output logic                                keep
);

  logic signed [rmh_pkg::SAMPLE_W-1:0] val_r;
  logic signed [rmh_pkg::SAMPLE_W-1:0] val_nxt;
  logic                                occupied;

  assign occupied = CW'(INDEX) < cnt;
  assign keep     = occupied && (IS_MAX ? (val_r >= cmd.key) : (val_r <= cmd.key));
  assign val      = val_r;

  always_comb begin
    unique case (cmd.op)
      rmh_pkg::OP_INSERT: val_nxt = keep ? val_r : (prev_keep ? cmd.key : prev_val);
      rmh_pkg::OP_POP:    val_nxt = next_val;
      default:            val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* rtl/core/rmh_chain.sv */
// A sorted chain of rmh_cell instances acting as one heap, best value in cell zero.
// Depends on rmh_pkg and rmh_cell.
module rmh_chain #(
  parameter int DEPTH  = 514,
  parameter int CW     = 10,
  parameter bit IS_MAX = 1'b1
) (
  input  logic                                clk,
  input  rmh_pkg::cell_cmd_t                  cmd,
  input  logic [CW-1:0]                       cnt,
  output logic signed [rmh_pkg::SAMPLE_W-1:0] top
);

  logic signed [rmh_pkg::SAMPLE_W-1:0] vals  [DEPTH];
  logic                                keeps [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [rmh_pkg::SAMPLE_W-1:0] prev_val;
    logic                                prev_keep;
    logic signed [rmh_pkg::SAMPLE_W-1:0] next_val;

    if (g == 0) begin : g_first
      assign prev_val  = cmd.key;
      assign prev_keep = 1'b1;
    end else begin : g_mid
      assign prev_val  = vals[g-1];
      assign prev_keep = keeps[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_val = vals[g];
    end else begin : g_inner
      assign next_val = vals[g+1];
    end

    rmh_cell #(
      .INDEX  (g),
      .CW     (CW),
      .IS_MAX (IS_MAX)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .cnt       (cnt),
      .prev_val  (prev_val),
      .prev_keep (prev_keep),
      .next_val  (next_val),
      .val       (vals[g]),
      .keep      (keeps[g])
    );
  end

  assign top = vals[0];

endmodule
